// File: src/fpss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpss_pkg;

  localparam int COUNTER_BITS_DEF   = 10;
  localparam int MAGNITUDE_BITS_DEF = 12;

  localparam int THR_W     = 12;
  localparam int TICK_W    = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 12;
  localparam int PHASE_W   = 3;
  localparam int FIFO_DEPTH = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LAUNCH_THR     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURNOUT_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTLESS_THR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAUNCH_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BURNOUT_TICKS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTLESS_TICKS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COAST_TIMEOUT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUTE_DELAY    = 3'd7;

  // Reset values (thresholds are 1.8 g, 1.6 g and 0.3 g rounded to Q4.8)
  localparam logic [THR_W-1:0]  RST_LAUNCH_THR     = 12'd461;
  localparam logic [THR_W-1:0]  RST_BURNOUT_THR    = 12'd410;
  localparam logic [THR_W-1:0]  RST_WEIGHTLESS_THR = 12'd77;
  localparam logic [TICK_W-1:0] RST_LAUNCH_TICKS   = 10'd10;
  localparam logic [TICK_W-1:0] RST_BURNOUT_TICKS  = 10'd20;
  localparam logic [TICK_W-1:0] RST_WEIGHTLESS_TICKS = 10'd30;
  localparam logic [TICK_W-1:0] RST_COAST_TIMEOUT  = 10'd300;
  localparam logic [TICK_W-1:0] RST_CHUTE_DELAY    = 10'd150;

  // Phase codes on the result channel
  localparam logic [PHASE_W-1:0] PHASE_IDLE      = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_ASCENT    = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_COAST     = 3'd2;
  localparam logic [PHASE_W-1:0] PHASE_SEPARATED = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_DONE      = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_ASCENT    = 5'b00010,
    ST_COAST     = 5'b00100,
    ST_SEPARATED = 5'b01000,
    ST_DONE      = 5'b10000
  } state_t;

  typedef struct packed {
    logic [THR_W-1:0] launch;
    logic [THR_W-1:0] burnout;
    logic [THR_W-1:0] weightless;
  } thr_cfg_t;

  typedef struct packed {
    logic [TICK_W-1:0] launch;
    logic [TICK_W-1:0] burnout;
    logic [TICK_W-1:0] weightless;
    logic [TICK_W-1:0] coast_timeout;
    logic [TICK_W-1:0] chute_delay;
  } tick_cfg_t;

  // Classification of one tick
  typedef struct packed {
    logic above_launch;
    logic below_burnout;
    logic below_weightless;
  } flags_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               glider_release;
    logic               chute_release;
    logic               separation_event;
    logic               parachute_event;
  } result_t;

  function automatic logic [PHASE_W-1:0] phase_code(input state_t st);
    logic [PHASE_W-1:0] code;
    case (st)
      ST_IDLE:      code = PHASE_IDLE;
      ST_ASCENT:    code = PHASE_ASCENT;
      ST_COAST:     code = PHASE_COAST;
      ST_SEPARATED: code = PHASE_SEPARATED;
      ST_DONE:      code = PHASE_DONE;
      default:      code = PHASE_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: src/fpss_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface fpss_in_if #(
  parameter int MAGNITUDE_BITS = fpss_pkg::MAGNITUDE_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic [MAGNITUDE_BITS-1:0] accel_magnitude;

  modport source (output valid, output accel_magnitude, input ready);
  modport sink   (input valid, input accel_magnitude, output ready);
endinterface

interface fpss_out_if;
  logic                             valid;
  logic                             ready;
  logic [fpss_pkg::PHASE_W-1:0]     phase;
  logic                             glider_release;
  logic                             chute_release;
  logic                             separation_event;
  logic                             parachute_event;

  modport source (output valid, output phase, output glider_release, output chute_release,
                  output separation_event, output parachute_event, input ready);
  modport sink   (input valid, input phase, input glider_release, input chute_release,
                  input separation_event, input parachute_event, output ready);
endinterface

`default_nettype wire

// File: src/flight_phase_separation_sequencer.sv
// Flight phase separation sequencer.
// in_chan carries one tick per transaction: the filtered acceleration magnitude,
// unsigned Q4.8 g. out_chan returns exactly one result per tick: phase, the two
// release levels and the one-tick separation and parachute event flags.
// Both channels use valid/ready; a transaction completes when both are high.
// The cfg_ port writes one of eight registers (thresholds, tick counts) at any
// edge with cfg_we high; write it only while no tick is in flight.
// A tick passes the classify register, the two-entry queue, then the state and
// output register. Throughput: one tick per clock while the receiver keeps up,
// set by the state update in the back end; input is taken while a finished
// result still waits at the output.
// If the receiver stalls, the result register holds, the queue fills and then
// in_chan.ready drops; no result is lost.
// Synchronous active-low reset returns to idle, clears the counters and loads
// the register reset values; the queue and output come up empty.
`timescale 1ns / 1ps
`default_nettype none

module flight_phase_separation_sequencer #(
  parameter int COUNTER_BITS   = fpss_pkg::COUNTER_BITS_DEF,
  parameter int MAGNITUDE_BITS = fpss_pkg::MAGNITUDE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  fpss_in_if.sink                                 in_chan,
  fpss_out_if.source                              out_chan,
  input  wire logic                               cfg_we,
  input  wire logic [fpss_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [fpss_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  fpss_pkg::thr_cfg_t  thr_r;
  fpss_pkg::tick_cfg_t ticks_r;

  logic              cls_valid, cls_ready;
  fpss_pkg::flags_t  cls_flags;
  logic              q_valid, q_ready;
  fpss_pkg::flags_t  q_flags;
  fpss_pkg::result_t res;
  logic [MAGNITUDE_BITS-1:0] in_mag;
  logic [fpss_pkg::TICK_W-1:0] wtick;

  assign in_mag = MAGNITUDE_BITS'(in_chan.accel_magnitude);
  assign wtick  = cfg_wdata[fpss_pkg::TICK_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.launch          <= fpss_pkg::RST_LAUNCH_THR;
      thr_r.burnout         <= fpss_pkg::RST_BURNOUT_THR;
      thr_r.weightless      <= fpss_pkg::RST_WEIGHTLESS_THR;
      ticks_r.launch        <= fpss_pkg::RST_LAUNCH_TICKS;
      ticks_r.burnout       <= fpss_pkg::RST_BURNOUT_TICKS;
      ticks_r.weightless    <= fpss_pkg::RST_WEIGHTLESS_TICKS;
      ticks_r.coast_timeout <= fpss_pkg::RST_COAST_TIMEOUT;
      ticks_r.chute_delay   <= fpss_pkg::RST_CHUTE_DELAY;
    end else if (cfg_we) begin
      case (cfg_idx)
        fpss_pkg::CFG_LAUNCH_THR:       thr_r.launch          <= cfg_wdata;
        fpss_pkg::CFG_BURNOUT_THR:      thr_r.burnout         <= cfg_wdata;
        fpss_pkg::CFG_WEIGHTLESS_THR:   thr_r.weightless      <= cfg_wdata;
        fpss_pkg::CFG_LAUNCH_TICKS:     ticks_r.launch        <= wtick;
        fpss_pkg::CFG_BURNOUT_TICKS:    ticks_r.burnout       <= wtick;
        fpss_pkg::CFG_WEIGHTLESS_TICKS: ticks_r.weightless    <= wtick;
        fpss_pkg::CFG_COAST_TIMEOUT:    ticks_r.coast_timeout <= wtick;
        fpss_pkg::CFG_CHUTE_DELAY:      ticks_r.chute_delay   <= wtick;
        default: begin
        end
      endcase
    end
  end

  fpss_front #(
    .MAGNITUDE_BITS(MAGNITUDE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_mag    (in_mag),
    .thr       (thr_r),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls_flags (cls_flags)
  );

  fpss_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cls_valid),
    .wr_ready (cls_ready),
    .wr_data  (cls_flags),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_flags)
  );

  fpss_back #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_valid (q_valid),
    .cls_ready (q_ready),
    .cls_flags (q_flags),
    .ticks     (ticks_r),
    .res_valid (out_chan.valid),
    .res_ready (out_chan.ready),
    .res       (res)
  );

  assign out_chan.phase            = res.phase;
  assign out_chan.glider_release   = res.glider_release;
  assign out_chan.chute_release    = res.chute_release;
  assign out_chan.separation_event = res.separation_event;
  assign out_chan.parachute_event  = res.parachute_event;

endmodule

`default_nettype wire

// File: src/fpss_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fpss_front #(
  parameter int MAGNITUDE_BITS = fpss_pkg::MAGNITUDE_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic [MAGNITUDE_BITS-1:0] in_mag,
  input  wire fpss_pkg::thr_cfg_t        thr,
  output      logic                      cls_valid,
  input  wire logic                      cls_ready,
  output      fpss_pkg::flags_t          cls_flags
);

  localparam int CMP_W = (MAGNITUDE_BITS > fpss_pkg::THR_W) ? MAGNITUDE_BITS
                                                             : fpss_pkg::THR_W;

  logic             valid_r, valid_nxt;
  fpss_pkg::flags_t flags_r, flags_nxt;
  logic [CMP_W-1:0] mag_ext;
  logic             take;

  assign mag_ext  = CMP_W'(in_mag);
  assign in_ready = !valid_r || cls_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    flags_nxt = flags_r;
    if (take) begin
      valid_nxt                  = 1'b1;
      flags_nxt.above_launch     = mag_ext > CMP_W'(thr.launch);
      flags_nxt.below_burnout    = mag_ext < CMP_W'(thr.burnout);
      flags_nxt.below_weightless = mag_ext < CMP_W'(thr.weightless);
    end else if (cls_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    flags_r <= flags_nxt;
  end

  assign cls_valid = valid_r;
  assign cls_flags = flags_r;

endmodule

`default_nettype wire

// File: src/fpss_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module fpss_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output      logic             wr_ready,
  input  wire fpss_pkg::flags_t wr_data,
  output      logic             rd_valid,
  input  wire logic             rd_ready,
  output      fpss_pkg::flags_t rd_data
);

  localparam int DEPTH = fpss_pkg::FIFO_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fpss_pkg::flags_t  mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push, pop;

  assign wr_ready = count_r != CNT_W'(DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: src/fpss_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fpss_back #(
  parameter int COUNTER_BITS = fpss_pkg::COUNTER_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cls_valid,
  output      logic               cls_ready,
  input  wire fpss_pkg::flags_t   cls_flags,
  input  wire fpss_pkg::tick_cfg_t ticks,
  output      logic               res_valid,
  input  wire logic               res_ready,
  output      fpss_pkg::result_t  res
);

  localparam int CW = (COUNTER_BITS > fpss_pkg::TICK_W) ? COUNTER_BITS : fpss_pkg::TICK_W;

  fpss_pkg::state_t     state_r, state_nxt;
  logic [COUNTER_BITS-1:0] phase_cnt_r, phase_cnt_nxt;
  logic [COUNTER_BITS-1:0] wl_cnt_r, wl_cnt_nxt;
  logic [COUNTER_BITS-1:0] phase_inc, wl_inc;
  logic                 out_valid_r, out_valid_nxt;
  fpss_pkg::result_t    out_r, out_nxt;
  logic                 step;
  logic                 sep_ev, chute_ev;

  assign cls_ready = !out_valid_r || res_ready;
  assign step      = cls_valid && cls_ready;

  // Counters stick at all ones
  assign phase_inc = (&phase_cnt_r) ? phase_cnt_r : phase_cnt_r + 1'b1;
  assign wl_inc    = (&wl_cnt_r) ? wl_cnt_r : wl_cnt_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    phase_cnt_nxt = phase_cnt_r;
    wl_cnt_nxt    = wl_cnt_r;
    sep_ev        = 1'b0;
    chute_ev      = 1'b0;
    case (state_r)
      fpss_pkg::ST_IDLE: begin
        if (cls_flags.above_launch) begin
          if (CW'(phase_inc) >= CW'(ticks.launch)) begin
            state_nxt     = fpss_pkg::ST_ASCENT;
            phase_cnt_nxt = '0;
          end else begin
            phase_cnt_nxt = phase_inc;
          end
        end else begin
          phase_cnt_nxt = '0;
        end
      end
      fpss_pkg::ST_ASCENT: begin
        if (cls_flags.below_burnout) begin
          if (CW'(phase_inc) >= CW'(ticks.burnout)) begin
            state_nxt     = fpss_pkg::ST_COAST;
            phase_cnt_nxt = '0;
          end else begin
            phase_cnt_nxt = phase_inc;
          end
        end else begin
          phase_cnt_nxt = '0;
        end
      end
      fpss_pkg::ST_COAST: begin
        wl_cnt_nxt = cls_flags.below_weightless ? wl_inc : '0;
        // Compare the coast timer before it advances
        if (CW'(wl_cnt_nxt) >= CW'(ticks.weightless) ||
            CW'(phase_cnt_r) >= CW'(ticks.coast_timeout)) begin
          sep_ev        = 1'b1;
          wl_cnt_nxt    = '0;
          state_nxt     = fpss_pkg::ST_SEPARATED;
          phase_cnt_nxt = '0;
        end else begin
          phase_cnt_nxt = phase_inc;
        end
      end
      fpss_pkg::ST_SEPARATED: begin
        if (CW'(phase_inc) >= CW'(ticks.chute_delay)) begin
          chute_ev      = 1'b1;
          state_nxt     = fpss_pkg::ST_DONE;
          phase_cnt_nxt = '0;
        end else begin
          phase_cnt_nxt = phase_inc;
        end
      end
      fpss_pkg::ST_DONE: begin
        state_nxt = fpss_pkg::ST_DONE;
      end
      default: begin
        state_nxt = fpss_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (step) begin
      out_valid_nxt            = 1'b1;
      out_nxt.phase            = fpss_pkg::phase_code(state_nxt);
      out_nxt.glider_release   = (state_nxt == fpss_pkg::ST_SEPARATED) ||
                                 (state_nxt == fpss_pkg::ST_DONE);
      out_nxt.chute_release    = state_nxt == fpss_pkg::ST_DONE;
      out_nxt.separation_event = sep_ev;
      out_nxt.parachute_event  = chute_ev;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpss_pkg::ST_IDLE;
      phase_cnt_r <= '0;
      wl_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        state_r     <= state_nxt;
        phase_cnt_r <= phase_cnt_nxt;
        wl_cnt_r    <= wl_cnt_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

`default_nettype wire

// File: test/tb_flight_phase_separation_sequencer.sv
`timescale 1ns / 1ps

module tb_flight_phase_separation_sequencer;
  import fpss_pkg::*;

  localparam int MAG_W       = MAGNITUDE_BITS_DEF;
  localparam int CNT_W       = COUNTER_BITS_DEF;
  localparam int MAG_MAX     = (1 << MAG_W) - 1;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [MAG_W-1:0]      mag_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  fpss_in_if  in_if ();
  fpss_out_if out_if ();

  logic                 tick_valid   = 1'b0;
  mag_t                 tick_mag     = '0;
  logic                 result_ready = 1'b0;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx      = '0;
  cfg_data_t            cfg_wdata    = '0;

  assign in_if.valid           = tick_valid;
  assign in_if.accel_magnitude = tick_mag;
  assign out_if.ready          = result_ready;

  flight_phase_separation_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Flight predictor: its own copy of the registers and the sequencer state
  thr_cfg_t  thr_cfg  = '{launch: RST_LAUNCH_THR, burnout: RST_BURNOUT_THR,
                          weightless: RST_WEIGHTLESS_THR};
  tick_cfg_t tick_cfg = '{launch: RST_LAUNCH_TICKS, burnout: RST_BURNOUT_TICKS,
                          weightless: RST_WEIGHTLESS_TICKS,
                          coast_timeout: RST_COAST_TIMEOUT,
                          chute_delay: RST_CHUTE_DELAY};
  logic [PHASE_W-1:0] flight_phase_q   = PHASE_IDLE;
  count_t             phase_count      = '0;
  count_t             weightless_count = '0;

  result_t expected_flight [$];

  int    error_count     = 0;
  int    ticks_sent      = 0;
  int    results_checked = 0;
  int    reg_writes      = 0;
  int    cycle_count     = 0;
  int    rx_wait         = 0;
  bit    tx_eager        = 1'b0;
  logic  rx_eager        = 1'b0;
  logic  rx_hold         = 1'b0;
  string separation_cause = "none";

  function automatic count_t count_up(input count_t c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic result_t advance_flight(input mag_t mag);
    result_t res;
    logic    sep_fire;
    logic    chute_fire;
    sep_fire   = 1'b0;
    chute_fire = 1'b0;
    case (flight_phase_q)
      PHASE_IDLE: begin
        if (mag > thr_cfg.launch) begin
          phase_count = count_up(phase_count);
          if (phase_count >= tick_cfg.launch) begin
            flight_phase_q = PHASE_ASCENT;
            phase_count    = '0;
          end
        end else begin
          phase_count = '0;
        end
      end
      PHASE_ASCENT: begin
        if (mag < thr_cfg.burnout) begin
          phase_count = count_up(phase_count);
          if (phase_count >= tick_cfg.burnout) begin
            flight_phase_q = PHASE_COAST;
            phase_count    = '0;
          end
        end else begin
          phase_count = '0;
        end
      end
      PHASE_COAST: begin
        if (mag < thr_cfg.weightless) weightless_count = count_up(weightless_count);
        else weightless_count = '0;
        // timeout is compared against the count before this tick adds to it
        if (weightless_count >= tick_cfg.weightless ||
            phase_count >= tick_cfg.coast_timeout) begin
          sep_fire         = 1'b1;
          weightless_count = '0;
          flight_phase_q   = PHASE_SEPARATED;
          phase_count      = '0;
        end else begin
          phase_count = count_up(phase_count);
        end
      end
      PHASE_SEPARATED: begin
        phase_count = count_up(phase_count);
        if (phase_count >= tick_cfg.chute_delay) begin
          chute_fire     = 1'b1;
          flight_phase_q = PHASE_DONE;
          phase_count    = '0;
        end
      end
      default: ;
    endcase
    res.phase            = flight_phase_q;
    res.glider_release   = (flight_phase_q == PHASE_SEPARATED) || (flight_phase_q == PHASE_DONE);
    res.chute_release    = (flight_phase_q == PHASE_DONE);
    res.separation_event = sep_fire;
    res.parachute_event  = chute_fire;
    return res;
  endfunction

  function automatic mag_t random_mag();
    return mag_t'($urandom_range(MAG_MAX, 0));
  endfunction

  // A tick that advances the count of the current phase, or one that clears it
  function automatic mag_t counting_mag(input int thr, input bit count_above);
    return count_above ? mag_t'($urandom_range(MAG_MAX, thr + 1))
                       : mag_t'($urandom_range(thr - 1, 0));
  endfunction

  function automatic mag_t breaking_mag(input int thr, input bit count_above);
    return count_above ? mag_t'($urandom_range(thr, 0))
                       : mag_t'($urandom_range(MAG_MAX, thr));
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic send_tick(input mag_t mag);
    int gap;
    // reshuffle the pacing now and then so both busy and idle stretches occur
    if ($urandom_range(29, 0) == 0) begin
      tx_eager = ($urandom_range(2, 0) == 0);
      rx_eager <= ($urandom_range(2, 0) == 0);
    end
    gap = tx_eager ? 0 : $urandom_range(13, 0);
    if (gap > 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick_mag   <= mag;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    expected_flight.push_back(advance_flight(mag));
    ticks_sent++;
  endtask

  task automatic wait_drain();
    tick_valid <= 1'b0;
    @(posedge clk);
    while (expected_flight.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input cfg_data_t data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LAUNCH_THR:       thr_cfg.launch             = data;
      CFG_BURNOUT_THR:      thr_cfg.burnout            = data;
      CFG_WEIGHTLESS_THR:   thr_cfg.weightless         = data;
      CFG_LAUNCH_TICKS:     tick_cfg.launch            = data[TICK_W-1:0];
      CFG_BURNOUT_TICKS:    tick_cfg.burnout           = data[TICK_W-1:0];
      CFG_WEIGHTLESS_TICKS: tick_cfg.weightless        = data[TICK_W-1:0];
      CFG_COAST_TIMEOUT:    tick_cfg.coast_timeout     = data[TICK_W-1:0];
      CFG_CHUTE_DELAY:      tick_cfg.chute_delay       = data[TICK_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic hold_result_channel(input int cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  // Runs of counting ticks kept shorter than the count, each ended by a clearing tick
  task automatic send_broken_runs(input int total, input int run_max, input int thr,
                                  input bit count_above);
    int sent;
    int len;
    sent = 0;
    while (sent < total) begin
      len = $urandom_range(run_max, 1);
      repeat (len) send_tick(counting_mag(thr, count_above));
      send_tick(breaking_mag(thr, count_above));
      sent += len + 1;
      if ($urandom_range(7, 0) == 0) wait_drain();
    end
  endtask

  task automatic send_until_phase_leaves(input logic [PHASE_W-1:0] ph, input int thr,
                                         input bit count_above);
    while (flight_phase_q == ph) begin
      if ($urandom_range(5, 0) == 0) send_tick(breaking_mag(thr, count_above));
      else send_tick(counting_mag(thr, count_above));
    end
  endtask

  task automatic test_directed_defaults();
    mag_t corner_ticks [9] = '{12'h000, 12'hFFF, 12'hAAA, 12'h555, RST_LAUNCH_THR,
                               RST_BURNOUT_THR, RST_BURNOUT_THR - 1'b1,
                               RST_WEIGHTLESS_THR, RST_WEIGHTLESS_THR - 1'b1};
    foreach (corner_ticks[i]) send_tick(corner_ticks[i]);
    // three high ticks cleared by a tick on the threshold, then a run one short of the launch count
    repeat (3) send_tick(RST_LAUNCH_THR + 1'b1);
    send_tick(RST_LAUNCH_THR);
    repeat (RST_LAUNCH_TICKS - 1) send_tick(RST_LAUNCH_THR + 1'b1);
    send_tick(12'h000);
  endtask

  task automatic test_idle_settings();
    int thr;
    int ticks;
    wait_drain();
    write_reg(CFG_LAUNCH_THR, 12'hFFF);
    write_reg(CFG_LAUNCH_TICKS, 12'd1);
    // park the later-phase registers at their extremes for now
    write_reg(CFG_BURNOUT_THR, 12'd0);
    write_reg(CFG_WEIGHTLESS_THR, 12'hFFF);
    write_reg(CFG_BURNOUT_TICKS, 12'd0);
    write_reg(CFG_WEIGHTLESS_TICKS, 12'hFFF);
    write_reg(CFG_COAST_TIMEOUT, 12'd0);
    write_reg(CFG_CHUTE_DELAY, 12'hFFF);
    repeat (40) send_tick(random_mag());

    // stall the result side long enough for the input to back up
    fork
      hold_result_channel(90);
    join_none
    tx_eager = 1'b1;
    repeat (30) send_tick(random_mag());
    tx_eager = 1'b0;

    wait_drain();
    write_reg(CFG_LAUNCH_THR, 12'd0);
    write_reg(CFG_LAUNCH_TICKS, 12'hFFF);
    repeat (60) send_tick(($urandom_range(7, 0) == 0) ? mag_t'(0)
                                                      : mag_t'($urandom_range(MAG_MAX, 1)));
    // clear the launch count so the shorter runs below start from zero
    send_tick(mag_t'(0));

    wait_drain();
    thr   = $urandom_range(3000, 100);
    ticks = $urandom_range(30, 8);
    write_reg(CFG_LAUNCH_THR, cfg_data_t'(thr));
    write_reg(CFG_LAUNCH_TICKS, cfg_data_t'(ticks));
    send_broken_runs(80, ticks - 1, thr, 1'b1);
  endtask

  task automatic test_launch();
    wait_drain();
    write_reg(CFG_LAUNCH_THR, RST_LAUNCH_THR);
    // upper bits are dropped, so this leaves a zero count: the first high tick launches
    write_reg(CFG_LAUNCH_TICKS, 12'h400);
    send_tick(RST_LAUNCH_THR);
    send_until_phase_leaves(PHASE_IDLE, RST_LAUNCH_THR, 1'b1);
  endtask

  task automatic test_ascent();
    int ticks;
    wait_drain();
    write_reg(CFG_BURNOUT_THR, 12'd0);
    write_reg(CFG_BURNOUT_TICKS, 12'd1);
    repeat (40) send_tick(random_mag());
    wait_drain();
    write_reg(CFG_BURNOUT_THR, 12'hFFF);
    write_reg(CFG_BURNOUT_TICKS, 12'h3FF);
    repeat (50) send_tick(($urandom_range(7, 0) == 0) ? mag_t'(MAG_MAX)
                                                      : mag_t'($urandom_range(MAG_MAX - 1, 0)));
    // clear the burnout count so the shorter runs below start from zero
    send_tick(mag_t'(MAG_MAX));
    wait_drain();
    ticks = $urandom_range(12, 3);
    write_reg(CFG_BURNOUT_THR, RST_BURNOUT_THR);
    write_reg(CFG_BURNOUT_TICKS, cfg_data_t'(ticks));
    send_broken_runs(60, ticks - 1, RST_BURNOUT_THR, 1'b0);
    wait_drain();
    if ($urandom_range(2, 0) == 0) write_reg(CFG_BURNOUT_TICKS, 12'd0);
    send_until_phase_leaves(PHASE_ASCENT, RST_BURNOUT_THR, 1'b0);
  endtask

  task automatic test_coast();
    int ticks;
    wait_drain();
    write_reg(CFG_WEIGHTLESS_THR, 12'd0);
    write_reg(CFG_WEIGHTLESS_TICKS, 12'd1);
    write_reg(CFG_COAST_TIMEOUT, 12'h3FF);
    repeat (40) send_tick(random_mag());
    wait_drain();
    write_reg(CFG_WEIGHTLESS_THR, 12'hFFF);
    write_reg(CFG_WEIGHTLESS_TICKS, 12'h3FF);
    repeat (40) send_tick(($urandom_range(7, 0) == 0) ? mag_t'(MAG_MAX)
                                                      : mag_t'($urandom_range(MAG_MAX - 1, 0)));
    // clear the weightless count so the shorter runs below start from zero
    send_tick(mag_t'(MAG_MAX));
    wait_drain();
    ticks = $urandom_range(12, 3);
    write_reg(CFG_WEIGHTLESS_THR, RST_WEIGHTLESS_THR);
    write_reg(CFG_WEIGHTLESS_TICKS, cfg_data_t'(ticks));
    send_broken_runs(40, ticks - 1, RST_WEIGHTLESS_THR, 1'b0);
    wait_drain();
    case ($urandom_range(2, 0))
      0: begin
        separation_cause = "a weightless run";
        send_until_phase_leaves(PHASE_COAST, RST_WEIGHTLESS_THR, 1'b0);
      end
      1: begin
        // land the timeout a few ticks ahead and stay out of weightlessness
        separation_cause = "the coast timeout";
        write_reg(CFG_COAST_TIMEOUT,
                  cfg_data_t'(int'(phase_count) + $urandom_range(5, 1)));
        while (flight_phase_q == PHASE_COAST)
          send_tick(breaking_mag(RST_WEIGHTLESS_THR, 1'b0));
      end
      default: begin
        separation_cause = "a zero coast timeout";
        write_reg(CFG_COAST_TIMEOUT, 12'd0);
        send_tick(random_mag());
      end
    endcase
  endtask

  task automatic test_separated();
    wait_drain();
    case ($urandom_range(2, 0))
      0:       write_reg(CFG_CHUTE_DELAY, 12'd0);
      1:       write_reg(CFG_CHUTE_DELAY, 12'd1);
      default: write_reg(CFG_CHUTE_DELAY, cfg_data_t'($urandom_range(40, 2)));
    endcase
    while (flight_phase_q == PHASE_SEPARATED) send_tick(random_mag());
  endtask

  task automatic test_done_hold();
    wait_drain();
    // settings that would launch at once from idle must not disturb done
    write_reg(CFG_LAUNCH_THR, 12'd0);
    write_reg(CFG_LAUNCH_TICKS, 12'd0);
    repeat (70) send_tick(random_mag());
    wait_drain();
    fork
      hold_result_channel(60);
    join_none
    tx_eager = 1'b1;
    repeat (30) send_tick(random_mag());
    tx_eager = 1'b0;
    wait_drain();
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst_n) begin
      result_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_flight.size() == 0) begin
          report_error("result transaction with no tick outstanding");
        end else begin
          want = expected_flight.pop_front();
          if (out_if.phase !== want.phase)
            report_error($sformatf("phase %0d, expected %0d", out_if.phase, want.phase));
          if (out_if.glider_release !== want.glider_release)
            report_error($sformatf("glider_release %b, expected %b",
                                   out_if.glider_release, want.glider_release));
          if (out_if.chute_release !== want.chute_release)
            report_error($sformatf("chute_release %b, expected %b",
                                   out_if.chute_release, want.chute_release));
          if (out_if.separation_event !== want.separation_event)
            report_error($sformatf("separation_event %b, expected %b",
                                   out_if.separation_event, want.separation_event));
          if (out_if.parachute_event !== want.parachute_event)
            report_error($sformatf("parachute_event %b, expected %b",
                                   out_if.parachute_event, want.parachute_event));
        end
        results_checked++;
        rx_wait = rx_eager ? 0 : $urandom_range(13, 0);
      end
      if (rx_hold || rx_wait > 0) begin
        result_ready <= 1'b0;
        if (rx_wait > 0) rx_wait--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, expected_flight.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_defaults();
    test_idle_settings();
    test_launch();
    test_ascent();
    test_coast();
    test_separated();
    test_done_hold();
    wait_drain();
    repeat (10) @(posedge clk);
    $display("Flew %0d ticks through idle, ascent, coast, separated and done; %0d results checked.",
             ticks_sent, results_checked);
    $display("Separation came from %s; %0d register writes, two long result stalls.",
             separation_cause, reg_writes);
    if (error_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
src/fpss_pkg.sv
src/fpss_ifs.sv
src/fpss_front.sv
src/fpss_fifo.sv
src/fpss_back.sv
src/flight_phase_separation_sequencer.sv
test/tb_flight_phase_separation_sequencer.sv
